FILE: rtl/psfd_pkg.sv
// Shared types, constants and scaling helpers for the particulate sensor frame decoder.
// Used by psfd_parser, psfd_divider and particulate_sensor_frame_decoder_core.
package psfd_pkg;

	// Frame formats selected by the sensor_type register.
	localparam logic [1:0] TYPE_TEN    = 2'd0;
	localparam logic [1:0] TYPE_NINE   = 2'd1;
	localparam logic [1:0] TYPE_THIRTY = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_SENSOR_TYPE   = 1'b0;
	localparam logic CFG_AVERAGE_COUNT = 1'b1;

	localparam logic [1:0] SENSOR_TYPE_RESET   = TYPE_TEN;
	localparam logic [7:0] AVERAGE_COUNT_RESET = 8'd10;

	// Fixed frame bytes.
	localparam logic [7:0] TEN_HEAD0    = 8'hAA;
	localparam logic [7:0] TEN_HEAD1    = 8'hC0;
	localparam logic [7:0] TEN_TAIL     = 8'hAB;
	localparam logic [7:0] NINE_HEAD0   = 8'hFF;
	localparam logic [7:0] NINE_HEAD1   = 8'h18;
	localparam logic [7:0] NINE_FIXED   = 8'h01;
	localparam logic [7:0] THIRTY_HEAD0 = 8'h42;
	localparam logic [7:0] THIRTY_HEAD1 = 8'h4D;
	localparam logic [7:0] THIRTY_LEN   = 8'h1C;
	localparam logic [7:0] ZERO_BYTE    = 8'h00;

	// PM10 reported by the nine-byte format, which does not measure it.
	localparam logic signed [23:0] PM10_NONE = -24'sd100;

	// Result of the byte parser, valid for one cycle after the closing byte.
	typedef struct packed {
		logic        good;
		logic [1:0]  kind;
		logic [15:0] pm10_raw;
		logic [15:0] pm25_raw;
	} frame_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [7:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [31:0] quotient;
	} div_rsp_t;

	function automatic logic [23:0] times10(input logic [15:0] v);
		logic [23:0] x;
		x = {8'd0, v};
		return (x << 3) + (x << 1);
	endfunction

	function automatic logic [23:0] times100(input logic [15:0] v);
		logic [23:0] x;
		x = {8'd0, v};
		return (x << 6) + (x << 5) + (x << 2);
	endfunction

	// Nine-byte format: integer and decimal part combined, then scaled by 20.
	function automatic logic [23:0] nine_scale(input logic [15:0] v);
		logic [23:0] hi;
		logic [23:0] y;
		hi = {16'd0, v[15:8]};
		y = (hi << 6) + (hi << 5) + (hi << 2) + {16'd0, v[7:0]};
		return (y << 4) + (y << 2);
	endfunction

endpackage

FILE: rtl/psfd_parser.sv
// Byte-level frame tracker: position, checksums, raw readings and frame checks.
// Depends on psfd_pkg.
module psfd_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [7:0]         rx_byte,
	input  logic [1:0]         sensor_type,
	output psfd_pkg::frame_t   frame
);
	import psfd_pkg::*;

	logic [4:0]  pos_q;
	logic [15:0] csum_q;
	logic [7:0]  rcv_hi_q;
	logic [15:0] pm10_raw_q;
	logic [15:0] pm25_raw_q;
	logic        good_q;
	logic [1:0]  kind_q;

	logic        ok;
	logic        last;
	logic        good;
	logic [15:0] csum_n;
	logic [15:0] csum_add;
	logic [7:0]  rcv_hi_n;
	logic [15:0] pm10_n;
	logic [15:0] pm25_n;
	logic [7:0]  csum_neg;

	assign csum_add = csum_q + {8'd0, rx_byte};
	assign csum_neg = 8'(8'd0 - csum_q[7:0]);

	always_comb begin
		ok = 1'b1;
		last = 1'b0;
		good = 1'b0;
		csum_n = csum_q;
		rcv_hi_n = rcv_hi_q;
		pm10_n = pm10_raw_q;
		pm25_n = pm25_raw_q;
		case (sensor_type)
			TYPE_TEN: begin
				case (pos_q)
					5'd0: ok = (rx_byte == TEN_HEAD0);
					5'd1: ok = (rx_byte == TEN_HEAD1);
					5'd2: begin
						pm25_n = {8'd0, rx_byte};
						csum_n = {8'd0, rx_byte};
					end
					5'd3: begin
						pm25_n = {rx_byte, pm25_raw_q[7:0]};
						csum_n = csum_add;
					end
					5'd4: begin
						pm10_n = {8'd0, rx_byte};
						csum_n = csum_add;
					end
					5'd5: begin
						pm10_n = {rx_byte, pm10_raw_q[7:0]};
						csum_n = csum_add;
					end
					5'd6, 5'd7: csum_n = csum_add;
					5'd8: ok = (rx_byte == csum_q[7:0]);
					5'd9: begin
						ok = (rx_byte == TEN_TAIL);
						last = 1'b1;
						good = ok;
					end
					default: ok = 1'b0;
				endcase
			end
			TYPE_NINE: begin
				case (pos_q)
					5'd0: ok = (rx_byte == NINE_HEAD0);
					5'd1: begin
						ok = (rx_byte == NINE_HEAD1);
						csum_n = {8'd0, NINE_HEAD1};
					end
					5'd2: ok = (rx_byte == ZERO_BYTE);
					5'd3: begin
						pm25_n = {rx_byte, pm25_raw_q[7:0]};
						csum_n = csum_add;
					end
					5'd4: begin
						pm25_n = {pm25_raw_q[15:8], rx_byte};
						csum_n = csum_add;
					end
					5'd5, 5'd7: csum_n = csum_add;
					5'd6: begin
						ok = (rx_byte == NINE_FIXED);
						csum_n = csum_add;
					end
					5'd8: begin
						last = 1'b1;
						good = (rx_byte == csum_neg);
					end
					default: ok = 1'b0;
				endcase
			end
			TYPE_THIRTY: begin
				if (pos_q == 5'd0) begin
					ok = (rx_byte == THIRTY_HEAD0);
					csum_n = {8'd0, THIRTY_HEAD0};
				end else if (pos_q <= 5'd29) begin
					csum_n = csum_add;
					case (pos_q)
						5'd1:  ok = (rx_byte == THIRTY_HEAD1);
						5'd2:  ok = (rx_byte == ZERO_BYTE);
						5'd3:  ok = (rx_byte == THIRTY_LEN);
						5'd12: pm25_n = {rx_byte, pm25_raw_q[7:0]};
						5'd13: pm25_n = {pm25_raw_q[15:8], rx_byte};
						5'd14: pm10_n = {rx_byte, pm10_raw_q[7:0]};
						5'd15: pm10_n = {pm10_raw_q[15:8], rx_byte};
						default: ok = 1'b1;
					endcase
				end else if (pos_q == 5'd30) begin
					rcv_hi_n = rx_byte;
				end else begin
					last = 1'b1;
					good = ({rcv_hi_q, rx_byte} == csum_q);
				end
			end
			default: ok = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 5'd0;
			csum_q <= 16'd0;
			rcv_hi_q <= 8'd0;
			pm10_raw_q <= 16'd0;
			pm25_raw_q <= 16'd0;
			good_q <= 1'b0;
			kind_q <= TYPE_TEN;
		end else begin
			good_q <= take & ok & good;
			if (take) begin
				pos_q <= (!ok || last) ? 5'd0 : 5'(pos_q + 5'd1);
				csum_q <= csum_n;
				rcv_hi_q <= rcv_hi_n;
				pm10_raw_q <= pm10_n;
				pm25_raw_q <= pm25_n;
				kind_q <= sensor_type;
			end
		end
	end

	assign frame.good = good_q;
	assign frame.kind = kind_q;
	assign frame.pm10_raw = pm10_raw_q;
	assign frame.pm25_raw = pm25_raw_q;

endmodule

FILE: rtl/psfd_divider.sv
// Restoring serial divider, one quotient bit per cycle: 32-bit dividend by 8-bit divisor.
// Depends on psfd_pkg.
module psfd_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  psfd_pkg::div_req_t  req,
	output psfd_pkg::div_rsp_t  rsp
);
	import psfd_pkg::*;

	logic [31:0] dvd_q;
	logic [7:0]  rem_q;
	logic [7:0]  divisor_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	logic [8:0] trial;
	logic       fits;
	logic [8:0] diff;

	assign trial = {rem_q, dvd_q[31]};
	assign fits = (trial >= {1'b0, divisor_q});
	assign diff = trial - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= 5'd0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == 5'd31);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= 5'(cnt_q + 5'd1);
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// The dividend shifts out at the top while quotient bits shift in at the bottom.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			divisor_q <= req.divisor;
			rem_q <= 8'd0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[7:0] : trial[7:0];
			dvd_q <= {dvd_q[30:0], fits};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quotient = dvd_q;

endmodule

FILE: rtl/particulate_sensor_frame_decoder_core.sv
// Particulate sensor frame decoder: each byte is accepted, then checked against its frame;
// a byte that completes a good frame is then accumulated and handed to the output register, and
// when it also closes an averaging window the serial divider, which produces one quotient bit per
// cycle, runs twice first (PM10 then PM2.5). The byte stall stays high until that work is done; a
// finished result waits in the output register while the next byte is taken.
// Depends on psfd_pkg, psfd_parser and psfd_divider.
module particulate_sensor_frame_decoder_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  logic [7:0]         rx_byte,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [23:0] pm10,
	output logic [22:0]        pm25,
	output logic               averages_updated,
	output logic signed [23:0] pm10_average,
	output logic [22:0]        pm25_average
);
	import psfd_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_CHECK    = 8'b0000_0010,
		S_ACCUM    = 8'b0000_0100,
		S_D10_GO   = 8'b0000_1000,
		S_D10_WAIT = 8'b0001_0000,
		S_D25_GO   = 8'b0010_0000,
		S_D25_WAIT = 8'b0100_0000,
		S_OUT      = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [1:0]         sensor_type_q;
	logic [7:0]         average_count_q;
	logic signed [23:0] p10_q;
	logic [22:0]        p25_q;
	logic signed [31:0] sum10_q;
	logic [31:0]        sum25_q;
	logic [7:0]         frames_q;
	logic               upd_q;
	logic signed [23:0] avg10_q;
	logic [22:0]        avg25_q;

	logic               result_valid_q;
	logic signed [23:0] pm10_q;
	logic [22:0]        pm25_q;
	logic               updated_q;
	logic signed [23:0] pm10_avg_q;
	logic [22:0]        pm25_avg_q;

	frame_t   frame;
	div_req_t div_req;
	div_rsp_t div_rsp;

	logic        take;
	logic [7:0]  need;
	logic [8:0]  frames_inc;
	logic [31:0] mag10;
	logic        out_free;

	assign take = byte_valid && !byte_stall;
	assign byte_stall = (state_q != S_IDLE);
	assign need = (average_count_q == 8'd0) ? 8'd1 : average_count_q;
	assign frames_inc = {1'b0, frames_q} + 9'd1;
	assign mag10 = sum10_q[31] ? 32'(-sum10_q) : 32'(sum10_q);
	assign out_free = !result_valid_q || !result_stall;

	psfd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.rx_byte    (rx_byte),
		.sensor_type(sensor_type_q),
		.frame      (frame)
	);

	always_comb begin
		div_req.start = (state_q == S_D10_GO) || (state_q == S_D25_GO);
		div_req.dividend = (state_q == S_D10_GO) ? mag10 : sum25_q;
		div_req.divisor = frames_q;
	end

	psfd_divider u_divider (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_type_q <= SENSOR_TYPE_RESET;
			average_count_q <= AVERAGE_COUNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SENSOR_TYPE:   sensor_type_q <= cfg_data[1:0];
				CFG_AVERAGE_COUNT: average_count_q <= cfg_data;
				default:           sensor_type_q <= sensor_type_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sum10_q <= 32'sd0;
			sum25_q <= 32'd0;
			frames_q <= 8'd0;
			upd_q <= 1'b0;
			avg10_q <= 24'sd0;
			avg25_q <= 23'd0;
			result_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_OUT) && out_free) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (take) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q <= frame.good ? S_ACCUM : S_IDLE;
				end
				S_ACCUM: begin
					sum10_q <= sum10_q + {{8{p10_q[23]}}, p10_q};
					sum25_q <= sum25_q + {9'd0, p25_q};
					frames_q <= frames_inc[7:0];
					if (frames_inc >= {1'b0, need}) begin
						upd_q <= 1'b1;
						state_q <= S_D10_GO;
					end else begin
						upd_q <= 1'b0;
						state_q <= S_OUT;
					end
				end
				S_D10_GO: begin
					state_q <= S_D10_WAIT;
				end
				S_D10_WAIT: begin
					if (div_rsp.done) begin
						avg10_q <= sum10_q[31] ? 24'(-div_rsp.quotient[23:0])
							: div_rsp.quotient[23:0];
						state_q <= S_D25_GO;
					end
				end
				S_D25_GO: begin
					state_q <= S_D25_WAIT;
				end
				S_D25_WAIT: begin
					if (div_rsp.done) begin
						avg25_q <= div_rsp.quotient[22:0];
						sum10_q <= 32'sd0;
						sum25_q <= 32'd0;
						frames_q <= 8'd0;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Scaled readings for the frame just checked.
	always_ff @(posedge clk) begin
		if (state_q == S_CHECK) begin
			case (frame.kind)
				TYPE_TEN: begin
					p10_q <= times10(frame.pm10_raw);
					p25_q <= 23'(times10(frame.pm25_raw));
				end
				TYPE_NINE: begin
					p10_q <= PM10_NONE;
					p25_q <= 23'(nine_scale(frame.pm25_raw));
				end
				default: begin
					p10_q <= times100(frame.pm10_raw);
					p25_q <= 23'(times100(frame.pm25_raw));
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && out_free) begin
			pm10_q <= p10_q;
			pm25_q <= p25_q;
			updated_q <= upd_q;
			pm10_avg_q <= avg10_q;
			pm25_avg_q <= avg25_q;
		end
	end

	assign result_valid = result_valid_q;
	assign pm10 = pm10_q;
	assign pm25 = pm25_q;
	assign averages_updated = updated_q;
	assign pm10_average = pm10_avg_q;
	assign pm25_average = pm25_avg_q;

endmodule

FILE: tb/tb_particulate_sensor_frame_decoder_core.sv
// Testbench for particulate_sensor_frame_decoder_core: feeds sensor bytes in all three frame
// formats, predicts every decoded reading and window average, and checks each result in order.
// Depends on psfd_pkg and the decoder RTL.
module tb_particulate_sensor_frame_decoder_core;
	import psfd_pkg::*;

	localparam logic [1:0] TYPE_UNUSED = 2'd3;
	localparam int QUIET_CYCLES = 120;
	localparam int RUN_LIMIT = 8_000_000;

	typedef struct packed {
		logic [23:0] pm10;
		logic [22:0] pm25;
		logic        updated;
		logic [23:0] pm10_avg;
		logic [22:0] pm25_avg;
	} reading_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic               cfg_index;
	logic [7:0]         cfg_data;
	logic               byte_valid;
	logic               byte_stall;
	logic [7:0]         rx_byte;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic signed [23:0] pm10;
	logic [22:0]        pm25;
	logic               averages_updated;
	logic signed [23:0] pm10_average;
	logic [22:0]        pm25_average;

	// Decoder state as the testbench predicts it.
	logic [1:0]  cur_type = SENSOR_TYPE_RESET;
	logic [7:0]  avg_count = AVERAGE_COUNT_RESET;
	logic [4:0]  frame_pos = '0;
	logic [15:0] run_sum = '0;
	logic [15:0] rx_sum = '0;
	logic [15:0] pm10_word = '0;
	logic [15:0] pm25_word = '0;
	longint      pm10_acc = 0;
	longint      pm25_acc = 0;
	int          window_frames = 0;
	longint      pm10_avg = 0;
	longint      pm25_avg = 0;

	reading_t    expected_readings[$];
	logic [7:0]  frame_buf[$];
	int          bytes_sent = 0;
	int          mismatch_count = 0;
	int          idle_pct = 0;
	int          stall_pct = 0;

	particulate_sensor_frame_decoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.rx_byte(rx_byte),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.pm10(pm10),
		.pm25(pm25),
		.averages_updated(averages_updated),
		.pm10_average(pm10_average),
		.pm25_average(pm25_average)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		result_stall <= arst_n && ($urandom_range(99) < stall_pct);
	end

	task automatic report_mismatch(input string field, input logic [23:0] want,
			input logic [23:0] got);
		if (mismatch_count < 200)
			$display("mismatch in %s: expected %0h, got %0h", field, want, got);
		mismatch_count++;
	endtask

	always @(posedge clk) begin : check_readings
		reading_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_readings.size() == 0) begin
				report_mismatch("unexpected reading", '0, pm10);
			end else begin
				want = expected_readings.pop_front();
				if (pm10 !== want.pm10)
					report_mismatch("pm10", want.pm10, pm10);
				if (pm25 !== want.pm25)
					report_mismatch("pm25", want.pm25, pm25);
				if (averages_updated !== want.updated)
					report_mismatch("averages_updated", want.updated, averages_updated);
				if (pm10_average !== want.pm10_avg)
					report_mismatch("pm10_average", want.pm10_avg, pm10_average);
				if (pm25_average !== want.pm25_avg)
					report_mismatch("pm25_average", want.pm25_avg, pm25_average);
			end
		end
	end

	// Advances the frame hunt by one byte and queues a reading when a good frame closes.
	task automatic decode_byte(input logic [7:0] b);
		logic [4:0]  pos;
		logic        ok;
		logic        last;
		logic        good;
		logic [7:0]  total;
		longint      p10;
		longint      p25;
		int          need;
		reading_t    r;
		pos = frame_pos;
		ok = 1'b1;
		last = 1'b0;
		good = 1'b0;
		p10 = 0;
		p25 = 0;
		case (cur_type)
			TYPE_TEN: begin
				case (pos)
					5'd0: ok = (b == TEN_HEAD0);
					5'd1: ok = (b == TEN_HEAD1);
					5'd2: begin
						pm25_word = {8'd0, b};
						run_sum = {8'd0, b};
					end
					5'd3: begin
						pm25_word[15:8] = b;
						run_sum += b;
					end
					5'd4: begin
						pm10_word = {8'd0, b};
						run_sum += b;
					end
					5'd5: begin
						pm10_word[15:8] = b;
						run_sum += b;
					end
					5'd6, 5'd7: run_sum += b;
					5'd8: ok = (b == run_sum[7:0]);
					5'd9: begin
						ok = (b == TEN_TAIL);
						last = 1'b1;
						good = ok;
					end
					default: ok = 1'b0;
				endcase
				p10 = pm10_word * 64'd10;
				p25 = pm25_word * 64'd10;
			end
			TYPE_NINE: begin
				case (pos)
					5'd0: ok = (b == NINE_HEAD0);
					5'd1: begin
						ok = (b == NINE_HEAD1);
						run_sum = {8'd0, NINE_HEAD1};
					end
					5'd2: ok = (b == ZERO_BYTE);
					5'd3: begin
						pm25_word[15:8] = b;
						run_sum += b;
					end
					5'd4: begin
						pm25_word[7:0] = b;
						run_sum += b;
					end
					5'd5, 5'd7: run_sum += b;
					5'd6: begin
						ok = (b == NINE_FIXED);
						run_sum += b;
					end
					5'd8: begin
						// The checksum byte plus the running sum must wrap to zero.
						total = b + run_sum[7:0];
						last = 1'b1;
						good = (total == 8'd0);
					end
					default: ok = 1'b0;
				endcase
				p10 = -100;
				p25 = (pm25_word[15:8] * 64'd100 + pm25_word[7:0]) * 64'd20;
			end
			TYPE_THIRTY: begin
				if (pos == 5'd0) begin
					ok = (b == THIRTY_HEAD0);
					run_sum = {8'd0, THIRTY_HEAD0};
				end else if (pos <= 5'd29) begin
					case (pos)
						5'd1: ok = (b == THIRTY_HEAD1);
						5'd2: ok = (b == ZERO_BYTE);
						5'd3: ok = (b == THIRTY_LEN);
						5'd12: pm25_word[15:8] = b;
						5'd13: pm25_word[7:0] = b;
						5'd14: pm10_word[15:8] = b;
						5'd15: pm10_word[7:0] = b;
						default: ;
					endcase
					run_sum += b;
				end else if (pos == 5'd30) begin
					rx_sum = {b, 8'd0};
				end else begin
					rx_sum[7:0] = b;
					last = 1'b1;
					good = (rx_sum == run_sum);
				end
				p10 = pm10_word * 64'd100;
				p25 = pm25_word * 64'd100;
			end
			default: ok = 1'b0;
		endcase

		frame_pos = (!ok || last) ? 5'd0 : pos + 5'd1;

		if (ok && good) begin
			need = (avg_count == 8'd0) ? 1 : int'(avg_count);
			pm10_acc += p10;
			pm25_acc += p25;
			window_frames++;
			r.updated = 1'b0;
			if (window_frames >= need) begin
				pm10_avg = pm10_acc / window_frames;
				pm25_avg = pm25_acc / window_frames;
				pm10_acc = 0;
				pm25_acc = 0;
				window_frames = 0;
				r.updated = 1'b1;
			end
			r.pm10 = p10[23:0];
			r.pm25 = p25[22:0];
			r.pm10_avg = pm10_avg[23:0];
			r.pm25_avg = pm25_avg[22:0];
			expected_readings.push_back(r);
		end
	endtask

	// Called just after the clock rises; returns as soon as the byte is taken, leaving valid high,
	// or, when an idle gap follows, at the end of that gap with valid low.
	task automatic send_byte(input logic [7:0] b);
		byte_valid <= 1'b1;
		rx_byte <= b;
		do
			@(posedge clk);
		while (byte_stall);
		decode_byte(b);
		bytes_sent++;
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			byte_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
	endtask

	task automatic send_frame(input int count);
		for (int i = 0; i < count; i++)
			send_byte(frame_buf[i]);
	endtask

	task automatic wait_for_quiet();
		byte_valid <= 1'b0;
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic idx, input logic [7:0] value);
		wait_for_quiet();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_SENSOR_TYPE)
			cur_type = value[1:0];
		else
			avg_count = value;
	endtask

	task automatic select_format(input logic [1:0] kind);
		write_register(CFG_SENSOR_TYPE, {6'd0, kind});
	endtask

	task automatic set_pace(input int idle, input int stall);
		idle_pct = idle;
		stall_pct = stall;
	endtask

	function automatic logic [15:0] pick_word();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(65535));
		endcase
	endfunction

	// Builds a well-formed frame of the given format with random filler bytes.
	task automatic fill_frame(input logic [1:0] kind, input logic [15:0] w10,
			input logic [15:0] w25);
		int          len;
		logic [7:0]  sum8;
		logic [15:0] sum16;
		case (kind)
			TYPE_TEN: len = 10;
			TYPE_NINE: len = 9;
			TYPE_THIRTY: len = 32;
			default: len = 10;
		endcase
		frame_buf.delete();
		for (int i = 0; i < len; i++)
			frame_buf.push_back(8'($urandom_range(255)));
		case (kind)
			TYPE_TEN: begin
				frame_buf[0] = TEN_HEAD0;
				frame_buf[1] = TEN_HEAD1;
				frame_buf[2] = w25[7:0];
				frame_buf[3] = w25[15:8];
				frame_buf[4] = w10[7:0];
				frame_buf[5] = w10[15:8];
				sum8 = '0;
				for (int i = 2; i < 8; i++)
					sum8 += frame_buf[i];
				frame_buf[8] = sum8;
				frame_buf[9] = TEN_TAIL;
			end
			TYPE_NINE: begin
				frame_buf[0] = NINE_HEAD0;
				frame_buf[1] = NINE_HEAD1;
				frame_buf[2] = ZERO_BYTE;
				frame_buf[3] = w25[15:8];
				frame_buf[4] = w25[7:0];
				frame_buf[6] = NINE_FIXED;
				sum8 = NINE_HEAD1;
				for (int i = 3; i < 8; i++)
					sum8 += frame_buf[i];
				frame_buf[8] = 8'd0 - sum8;
			end
			TYPE_THIRTY: begin
				frame_buf[0] = THIRTY_HEAD0;
				frame_buf[1] = THIRTY_HEAD1;
				frame_buf[2] = ZERO_BYTE;
				frame_buf[3] = THIRTY_LEN;
				frame_buf[12] = w25[15:8];
				frame_buf[13] = w25[7:0];
				frame_buf[14] = w10[15:8];
				frame_buf[15] = w10[7:0];
				sum16 = '0;
				for (int i = 0; i < 30; i++)
					sum16 += frame_buf[i];
				frame_buf[30] = sum16[15:8];
				frame_buf[31] = sum16[7:0];
			end
			default: ;
		endcase
	endtask

	task automatic send_good_frame(input logic [1:0] kind, input logic [15:0] w10,
			input logic [15:0] w25);
		fill_frame(kind, w10, w25);
		send_frame(frame_buf.size());
	endtask

	// Mostly well-formed frames, with corrupted, cut-short frames and line noise mixed in.
	task automatic random_burst(input int count);
		int start;
		int pick;
		int idx;
		start = bytes_sent;
		while (bytes_sent - start < count) begin
			pick = $urandom_range(99);
			fill_frame(cur_type, pick_word(), pick_word());
			if (pick < 72) begin
				send_frame(frame_buf.size());
			end else if (pick < 84) begin
				idx = $urandom_range(frame_buf.size() - 1);
				frame_buf[idx] ^= 8'($urandom_range(1, 255));
				send_frame(frame_buf.size());
			end else if (pick < 92) begin
				send_frame($urandom_range(1, frame_buf.size() - 1));
			end else begin
				frame_buf.delete();
				repeat ($urandom_range(1, 4)) frame_buf.push_back(8'($urandom_range(255)));
				send_frame(frame_buf.size());
			end
		end
	endtask

	task automatic test_ten_byte_format();
		set_pace(0, 0);
		send_good_frame(TYPE_TEN, 16'h0000, 16'h0000);
		send_good_frame(TYPE_TEN, 16'hFFFF, 16'hFFFF);
		send_good_frame(TYPE_TEN, 16'h1234, 16'hABCD);
	endtask

	task automatic test_nine_byte_format();
		select_format(TYPE_NINE);
		send_good_frame(TYPE_NINE, 16'h0000, 16'h0000);
		send_good_frame(TYPE_NINE, 16'hFFFF, 16'hFFFF);
		send_good_frame(TYPE_NINE, 16'h0000, 16'h0A32);
	endtask

	task automatic test_thirty_two_byte_format();
		select_format(TYPE_THIRTY);
		send_good_frame(TYPE_THIRTY, 16'h0000, 16'h0000);
		send_good_frame(TYPE_THIRTY, 16'hFFFF, 16'hFFFF);
	endtask

	task automatic test_framing_errors();
		logic [1:0] kind;
		int         idx;
		for (int k = 0; k < 3; k++) begin
			kind = 2'(k);
			select_format(kind);
			// Broken header, then the last byte, then the one before it.
			for (int spot = 0; spot < 3; spot++) begin
				fill_frame(kind, pick_word(), pick_word());
				case (spot)
					0: idx = 1;
					1: idx = frame_buf.size() - 1;
					default: idx = frame_buf.size() - 2;
				endcase
				frame_buf[idx] ^= 8'h01;
				send_frame(frame_buf.size());
			end
			send_good_frame(kind, pick_word(), pick_word());
		end
		select_format(TYPE_NINE);
		fill_frame(TYPE_NINE, pick_word(), pick_word());
		frame_buf[2] = NINE_FIXED;
		send_frame(frame_buf.size());
		fill_frame(TYPE_NINE, pick_word(), pick_word());
		frame_buf[6] = ZERO_BYTE;
		send_frame(frame_buf.size());
		// A second header byte is a mismatch and is not taken as a fresh start.
		select_format(TYPE_TEN);
		send_byte(TEN_HEAD0);
		send_good_frame(TYPE_TEN, pick_word(), pick_word());
		send_good_frame(TYPE_TEN, pick_word(), pick_word());
	endtask

	task automatic test_unused_format();
		select_format(TYPE_UNUSED);
		send_good_frame(TYPE_TEN, pick_word(), pick_word());
		send_good_frame(TYPE_NINE, pick_word(), pick_word());
		select_format(TYPE_TEN);
		send_good_frame(TYPE_TEN, pick_word(), pick_word());
	endtask

	task automatic test_format_switch();
		select_format(TYPE_TEN);
		fill_frame(TYPE_TEN, pick_word(), pick_word());
		send_frame(6);
		select_format(TYPE_THIRTY);
		fill_frame(TYPE_THIRTY, pick_word(), pick_word());
		for (int i = 6; i < 32; i++)
			send_byte(frame_buf[i]);
		send_good_frame(TYPE_THIRTY, pick_word(), pick_word());
		// Stopped past the end of the nine-byte frame before switching to it.
		fill_frame(TYPE_THIRTY, pick_word(), pick_word());
		send_frame(12);
		select_format(TYPE_NINE);
		send_good_frame(TYPE_NINE, pick_word(), pick_word());
		send_good_frame(TYPE_NINE, pick_word(), pick_word());
	endtask

	task automatic test_window_averaging();
		write_register(CFG_AVERAGE_COUNT, 8'd0);
		select_format(TYPE_TEN);
		send_good_frame(TYPE_TEN, pick_word(), pick_word());
		send_good_frame(TYPE_TEN, pick_word(), pick_word());
		// One window spanning all three formats.
		write_register(CFG_AVERAGE_COUNT, 8'd3);
		send_good_frame(TYPE_TEN, pick_word(), pick_word());
		select_format(TYPE_NINE);
		send_good_frame(TYPE_NINE, pick_word(), pick_word());
		select_format(TYPE_THIRTY);
		send_good_frame(TYPE_THIRTY, pick_word(), pick_word());
		// A negative sum whose average must truncate toward zero.
		select_format(TYPE_NINE);
		send_good_frame(TYPE_NINE, pick_word(), pick_word());
		send_good_frame(TYPE_NINE, pick_word(), pick_word());
		select_format(TYPE_TEN);
		send_good_frame(TYPE_TEN, 16'h0001, pick_word());
		// Count lowered below the frames already in the window.
		write_register(CFG_AVERAGE_COUNT, 8'd5);
		repeat (3) send_good_frame(TYPE_TEN, pick_word(), pick_word());
		write_register(CFG_AVERAGE_COUNT, 8'd2);
		send_good_frame(TYPE_TEN, pick_word(), pick_word());
	endtask

	task automatic test_random_traffic();
		logic [1:0] kind;
		logic [7:0] count;
		int         budget;
		for (int phase = 0; phase < 12; phase++) begin
			kind = (phase == 7) ? TYPE_UNUSED : 2'(phase % 3);
			case (phase)
				0: count = 8'd1;
				1: count = 8'd255;
				2: count = 8'd0;
				5: count = 8'd255;
				default: count = 8'($urandom_range(2, 12));
			endcase
			case (phase % 4)
				0: set_pace(0, 0);
				1: set_pace(70, 0);
				2: set_pace(0, 70);
				default: set_pace(19, 19);
			endcase
			select_format(kind);
			write_register(CFG_AVERAGE_COUNT, count);
			budget = (kind == TYPE_UNUSED) ? 30 : 64;
			random_burst(budget / 2);
			if (phase % 4 == 2) begin
				// Hold the sender until the stalled results have all drained.
				byte_valid <= 1'b0;
				while (expected_readings.size() != 0)
					@(posedge clk);
			end
			random_burst(budget - budget / 2);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_SENSOR_TYPE;
		cfg_data <= 8'd0;
		byte_valid <= 1'b0;
		rx_byte <= 8'd0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_ten_byte_format();
		test_nine_byte_format();
		test_thirty_two_byte_format();
		test_framing_errors();
		test_unused_format();
		test_format_switch();
		test_window_averaging();
		test_random_traffic();

		wait_for_quiet();
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#(RUN_LIMIT);
		$display("Mismatches found");
		$finish;
	end

endmodule
